FILE: rtl/core/tofpo_pkg.sv
package tofpo_pkg;

    localparam int SINE_TABLE_BITS = 10;
    localparam int PHASE_BITS      = 32;
    localparam int SAMPLE_BITS     = 24;

    localparam int QUARTER_N = 1 << SINE_TABLE_BITS;
    localparam int ADDR_W    = SINE_TABLE_BITS + 1;
    localparam int MUL_A_W   = SAMPLE_BITS + 1;
    localparam int MUL_B_W   = 34;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int CFG_ADDR_W = 5;

    localparam longint ONE_S = longint'(1) << (SAMPLE_BITS - 1);
    localparam longint MAX_S = ONE_S - 1;

    localparam logic [31:0] HALF_PI_Q30    = 32'd1686629713;
    localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;

    localparam longint unsigned SINE_DIVS [0:4] = '{110, 72, 42, 20, 6};

    // Register indexes.
    localparam logic [2:0] REG_CARRIER_WAVE = 3'd0;
    localparam logic [2:0] REG_MOD_WAVE     = 3'd1;
    localparam logic [2:0] REG_FEEDBACK     = 3'd2;
    localparam logic [2:0] REG_MOD_MODE     = 3'd3;
    localparam logic [2:0] REG_MOD_RATIO    = 3'd4;
    localparam logic [2:0] REG_MOD_LEVEL    = 3'd5;
    localparam logic [2:0] REG_LFO_DEPTH    = 3'd6;

    // Wave shapes.
    localparam logic [1:0] WAVE_SINE     = 2'd0;
    localparam logic [1:0] WAVE_TRIANGLE = 2'd1;
    localparam logic [1:0] WAVE_SQUARE   = 2'd2;
    localparam logic [1:0] WAVE_SAW      = 2'd3;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef sample_t sine_rom_t [0:QUARTER_N];

    typedef struct packed {
        logic [1:0]  carrier_waveform;
        logic [1:0]  modulator_waveform;
        logic [15:0] feedback_amount;
        logic        pm_enable;
        logic [15:0] modulator_ratio;
        logic [15:0] modulator_level;
        logic [15:0] lfo_depth;
    } cfg_t;

    // Quarter-wave sine built from a Taylor series at elaboration time.
    function automatic sine_rom_t build_sine();
        sine_rom_t          rom;
        longint unsigned    x;
        longint unsigned    x2;
        longint unsigned    t;
        longint unsigned    s;
        longint unsigned    v;
        for (int i = 0; i <= QUARTER_N; i++) begin
            x  = (longint'(i) * longint'(HALF_PI_Q30)) / QUARTER_N;
            x2 = (x * x) >> 30;
            t  = longint'(1) << 30;
            for (int k = 0; k < 5; k++) begin
                t = (longint'(1) << 30) - ((x2 * t) >> 30) / SINE_DIVS[k];
            end
            s = (x * t) >> 30;
            v = (s * (longint'(1) << (SAMPLE_BITS - 1)) + (longint'(1) << 29)) >> 30;
            if (v > MAX_S) begin
                v = MAX_S;
            end
            rom[i] = sample_t'(v);
        end
        return rom;
    endfunction

    // Table address for a phase; the second and fourth quarters read mirrored.
    function automatic logic [ADDR_W-1:0] sine_addr(logic [31:0] p);
        logic [SINE_TABLE_BITS-1:0] idx;
        idx = p[29:30-SINE_TABLE_BITS];
        if (p[30]) begin
            return ADDR_W'(QUARTER_N) - {1'b0, idx};
        end
        return {1'b0, idx};
    endfunction

    function automatic sample_t wave_value(logic [1:0] shape, logic [31:0] p, sample_t rom_q);
        logic [63:0] a;
        logic [63:0] r;
        sample_t     res;
        a = ({34'd0, p[29:0]} << (SAMPLE_BITS - 1)) >> 30;
        r = ({33'd0, p[30:0]} << (SAMPLE_BITS - 1)) >> 31;
        case (shape)
            WAVE_SINE: begin
                res = p[31] ? -rom_q : rom_q;
            end
            WAVE_TRIANGLE: begin
                case (p[31:30])
                    2'd0: res = sample_t'(a);
                    2'd1: res = (a == 64'd0) ? sample_t'(MAX_S) : sample_t'(ONE_S - a);
                    2'd2: res = -sample_t'(a);
                    default: res = sample_t'(a - ONE_S);
                endcase
            end
            WAVE_SQUARE: begin
                res = (p[31] == p[30]) ? sample_t'(MAX_S) : sample_t'(-ONE_S);
            end
            default: begin
                res = p[31] ? sample_t'(r - ONE_S) : sample_t'(r);
            end
        endcase
        return res;
    endfunction

endpackage

FILE: rtl/core/tofpo_if.sv
interface tofpo_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic [31:0]        phase_step;
    logic signed [15:0] lfo;

    modport source (output valid, action, phase_step, lfo, input ready);
    modport sink   (input valid, action, phase_step, lfo, output ready);
endinterface

interface tofpo_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample;

    modport source (output valid, sample, input ready);
    modport sink   (input valid, sample, output ready);
endinterface

FILE: rtl/core/two_operator_fm_pm_oscillator_top.sv
// Channel  | Dir | Payload                        | Handshake
// in_ch    | in  | action, phase_step, lfo        | valid / ready
// out_ch   | out | sample (Q31)                   | valid / ready
// apb      | in  | 7 registers at 4*i             | psel / penable, pready tied high
//
// A sample tick steps through one shared multiplier and a registered sine ROM,
// in the order of the multiply chain of the modulator and carrier.
// A note-off word is taken while idle and starts no tick. Input is ready only when idle.
// The finished sample waits in an output register; a new tick can start while it
// waits, and only stalls in its last wave step if that register is still full.
// Reset (rst_n, asynchronous) clears phases, stored modulator output and control.
module two_operator_fm_pm_oscillator_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tofpo_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    tofpo_in_if.sink                          in_ch,
    tofpo_out_if.source                       out_ch
);
    import tofpo_pkg::*;

    // Sequencer steps. Each one issues at most one multiply.
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_FB    = 4'd1;   // feedback product ready
    localparam logic [3:0] ST_GAIN  = 4'd2;   // LFO gain product ready
    localparam logic [3:0] ST_MOFF  = 4'd3;   // modulator phase offset
    localparam logic [3:0] ST_MWAVE = 4'd4;   // modulator wave from ROM
    localparam logic [3:0] ST_MLEV  = 4'd5;   // apply level, then gain
    localparam logic [3:0] ST_MSAT  = 4'd6;   // saturate modulator output
    localparam logic [3:0] ST_COFF  = 4'd7;   // carrier phase offset
    localparam logic [3:0] ST_CWAVE = 4'd8;   // carrier wave, emit word
    localparam logic [3:0] ST_ADV   = 4'd9;   // advance both phases

    cfg_t cfg;

    tofpo_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic [3:0]                 state_reg, state_next;
    logic [PHASE_BITS-1:0]      cphase_reg, mphase_reg;
    logic [PHASE_BITS-1:0]      step_reg;
    logic signed [15:0]         lfo_reg;
    sample_t                    mlast_reg;
    sample_t                    fb_reg;
    logic signed [MUL_B_W-1:0]  g_reg;
    logic [31:0]                peff_reg;
    logic                       out_valid_reg;
    logic signed [31:0]         sample_reg;

    logic                       mul_en;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [MUL_P_W-1:0]  prod;

    tofpo_mul u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    logic [ADDR_W-1:0] rom_addr;
    sample_t           rom_q;

    tofpo_sine_rom u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .q    (rom_q)
    );

    logic                      accept;
    logic                      out_free;
    sample_t                   prod_s16;
    logic signed [SAMPLE_BITS+3:0] prod_s31;
    sample_t                   m_sat;
    sample_t                   off_src;
    logic [31:0]               offset;
    logic [31:0]               phase_eff;
    logic [1:0]                cur_shape;
    sample_t                   wave_q;
    logic signed [MUL_B_W-1:0] gain_sum;

    assign in_ch.ready   = (state_reg == ST_IDLE);
    assign accept        = in_ch.valid && in_ch.ready;
    assign out_free      = !out_valid_reg || out_ch.ready;
    assign out_ch.valid  = out_valid_reg;
    assign out_ch.sample = sample_reg;

    // Every product is floored, which is an arithmetic shift of the raw product.
    assign prod_s16 = prod[SAMPLE_BITS+15:16];
    assign prod_s31 = prod[MUL_P_W-1:31];

    always_comb
    begin
        if (prod_s31 > (SAMPLE_BITS+4)'(MAX_S))
        begin
            m_sat = sample_t'(MAX_S);
        end
        else if (prod_s31 < -(SAMPLE_BITS+4)'(ONE_S))
        begin
            m_sat = sample_t'(-ONE_S);
        end
        else
        begin
            m_sat = prod_s31[SAMPLE_BITS-1:0];
        end
    end

    // The gain is (1 - depth) + depth * lfo in Q1.31.
    assign gain_sum = MUL_B_W'({17'd65536 - {1'b0, cfg.lfo_depth}, 15'd0})
                    + prod[MUL_B_W-1:0];

    // Phase offset: cycles directly in FM mode, scaled by 1/(2pi) in PM mode.
    // In PM mode the product of the source and 1/(2pi) is already in prod.
    assign off_src = (state_reg == ST_MOFF) ? fb_reg : mlast_reg;

    always_comb
    begin
        if (cfg.pm_enable)
        begin
            offset = prod[SAMPLE_BITS+30:SAMPLE_BITS-1];
        end
        else
        begin
            offset = 32'({{(64-SAMPLE_BITS){off_src[SAMPLE_BITS-1]}}, off_src}
                         << (33 - SAMPLE_BITS));
        end
    end

    always_comb
    begin
        if (state_reg == ST_MOFF)
        begin
            phase_eff = (32'(mphase_reg) << (32 - PHASE_BITS)) + offset;
        end
        else
        begin
            phase_eff = (32'(cphase_reg) << (32 - PHASE_BITS)) + offset;
        end
    end

    assign rom_addr  = sine_addr(phase_eff);
    assign cur_shape = (state_reg == ST_MWAVE) ? cfg.modulator_waveform
                                               : cfg.carrier_waveform;
    assign wave_q    = wave_value(cur_shape, peff_reg, rom_q);

    // Shared multiplier operand selection.
    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            ST_IDLE:
            begin
                mul_en = accept && !in_ch.action;
                mul_a  = MUL_A_W'(mlast_reg);
                mul_b  = MUL_B_W'({1'b0, cfg.feedback_amount});
            end
            ST_FB:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(lfo_reg);
                mul_b  = MUL_B_W'({1'b0, cfg.lfo_depth});
            end
            ST_GAIN:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(fb_reg);
                mul_b  = MUL_B_W'({1'b0, INV_TWO_PI_Q32});
            end
            ST_MWAVE:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(wave_q);
                mul_b  = MUL_B_W'({1'b0, cfg.modulator_level});
            end
            ST_MLEV:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(prod_s16);
                mul_b  = g_reg;
            end
            ST_MSAT:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(m_sat);
                mul_b  = MUL_B_W'({1'b0, INV_TWO_PI_Q32});
            end
            ST_CWAVE:
            begin
                mul_en = out_free;
                mul_a  = MUL_A_W'({1'b0, cfg.modulator_ratio});
                mul_b  = MUL_B_W'({1'b0, step_reg});
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept && !in_ch.action) state_next = ST_FB;
            ST_FB:    state_next = ST_GAIN;
            ST_GAIN:  state_next = ST_MOFF;
            ST_MOFF:  state_next = ST_MWAVE;
            ST_MWAVE: state_next = ST_MLEV;
            ST_MLEV:  state_next = ST_MSAT;
            ST_MSAT:  state_next = ST_COFF;
            ST_COFF:  state_next = ST_CWAVE;
            ST_CWAVE: if (out_free) state_next = ST_ADV;
            ST_ADV:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cphase_reg    <= '0;
            mphase_reg    <= '0;
            mlast_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // A new word may be loaded in the same cycle the old one leaves.
            if (state_reg == ST_CWAVE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    // Note off clears the stored operator output only.
                    if (accept && in_ch.action)
                    begin
                        mlast_reg <= '0;
                    end
                end
                ST_MSAT:
                begin
                    mlast_reg <= m_sat;
                end
                ST_ADV:
                begin
                    cphase_reg <= cphase_reg + step_reg;
                    mphase_reg <= mphase_reg + prod[PHASE_BITS+7:8];
                end
                default: ;
            endcase
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            step_reg <= in_ch.phase_step[31:32-PHASE_BITS];
            lfo_reg  <= in_ch.lfo;
        end
        if (state_reg == ST_FB)
        begin
            fb_reg <= prod_s16;
        end
        if (state_reg == ST_GAIN)
        begin
            g_reg <= gain_sum;
        end
        if (state_reg == ST_MOFF || state_reg == ST_COFF)
        begin
            peff_reg <= phase_eff;
        end
        if (state_reg == ST_CWAVE && out_free)
        begin
            sample_reg <= 32'({wave_q, {(32-SAMPLE_BITS){1'b0}}});
        end
    end
endmodule

FILE: rtl/core/tofpo_sine_rom.sv
module tofpo_sine_rom (
    input  logic                           clk,
    input  logic [tofpo_pkg::ADDR_W-1:0]   addr,
    output tofpo_pkg::sample_t             q
);
    import tofpo_pkg::*;

    localparam sine_rom_t SINE_ROM = build_sine();

    sample_t q_reg;

    always_ff @(posedge clk)
    begin
        q_reg <= SINE_ROM[addr];
    end

    assign q = q_reg;
endmodule

FILE: rtl/core/tofpo_mul.sv
module tofpo_mul (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [tofpo_pkg::MUL_A_W-1:0] a,
    input  logic signed [tofpo_pkg::MUL_B_W-1:0] b,
    output logic signed [tofpo_pkg::MUL_P_W-1:0] p
);
    import tofpo_pkg::*;

    logic signed [MUL_P_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= a * b;
        end
    end

    assign p = p_reg;
endmodule

FILE: rtl/core/tofpo_apb_regs.sv
module tofpo_apb_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tofpo_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output tofpo_pkg::cfg_t                   cfg
);
    import tofpo_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.carrier_waveform   <= 2'd0;
            cfg_reg.modulator_waveform <= 2'd0;
            cfg_reg.feedback_amount    <= 16'd0;
            cfg_reg.pm_enable          <= 1'b0;
            cfg_reg.modulator_ratio    <= 16'd256;
            cfg_reg.modulator_level    <= 16'd65535;
            cfg_reg.lfo_depth          <= 16'd32768;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_CARRIER_WAVE: cfg_reg.carrier_waveform   <= pwdata[1:0];
                REG_MOD_WAVE:     cfg_reg.modulator_waveform <= pwdata[1:0];
                REG_FEEDBACK:     cfg_reg.feedback_amount    <= pwdata[15:0];
                REG_MOD_MODE:     cfg_reg.pm_enable          <= pwdata[0];
                REG_MOD_RATIO:    cfg_reg.modulator_ratio    <= pwdata[15:0];
                REG_MOD_LEVEL:    cfg_reg.modulator_level    <= pwdata[15:0];
                REG_LFO_DEPTH:    cfg_reg.lfo_depth          <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_CARRIER_WAVE: prdata = {30'd0, cfg_reg.carrier_waveform};
            REG_MOD_WAVE:     prdata = {30'd0, cfg_reg.modulator_waveform};
            REG_FEEDBACK:     prdata = {16'd0, cfg_reg.feedback_amount};
            REG_MOD_MODE:     prdata = {31'd0, cfg_reg.pm_enable};
            REG_MOD_RATIO:    prdata = {16'd0, cfg_reg.modulator_ratio};
            REG_MOD_LEVEL:    prdata = {16'd0, cfg_reg.modulator_level};
            REG_LFO_DEPTH:    prdata = {16'd0, cfg_reg.lfo_depth};
            default:          prdata = 32'd0;
        endcase
    end
endmodule

FILE: tb/tofpo_tb_pkg.sv
package tofpo_tb_pkg;

    import tofpo_pkg::*;

    // Keeps the voice's own state and the words still to come out.
    class voice_scoreboard;
        logic signed [31:0] pending_samples [$];
        int                 errors;
        int                 matched;

        logic [1:0]  car_shape;
        logic [1:0]  mod_shape;
        logic [15:0] fb_gain;
        logic        pm_mode;
        logic [15:0] ratio;
        logic [15:0] level;
        logic [15:0] depth;
        logic [31:0] car_phase;
        logic [31:0] mod_phase;
        longint      car_out;
        longint      mod_out;
        longint      quarter_sine [0:QUARTER_N];

        function new();
            longint unsigned x;
            longint unsigned x2;
            longint unsigned t;
            longint unsigned s;
            longint unsigned v;
            for (int i = 0; i <= QUARTER_N; i++)
            begin
                x  = (longint'(i) * 64'd1686629713) / QUARTER_N;
                x2 = (x * x) >> 30;
                t  = 64'd1 << 30;
                t  = (64'd1 << 30) - ((x2 * t) >> 30) / 110;
                t  = (64'd1 << 30) - ((x2 * t) >> 30) / 72;
                t  = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
                t  = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
                t  = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
                s  = (x * t) >> 30;
                v  = (s * (64'd1 << (SAMPLE_BITS - 1)) + (64'd1 << 29)) >> 30;
                quarter_sine[i] = (v > MAX_S) ? MAX_S : longint'(v);
            end
            errors  = 0;
            matched = 0;
            reset_state();
        endfunction

        function void reset_state();
            car_shape = WAVE_SINE;
            mod_shape = WAVE_SINE;
            fb_gain   = 0;
            pm_mode   = 0;
            ratio     = 256;
            level     = 65535;
            depth     = 32768;
            car_phase = 0;
            mod_phase = 0;
            car_out   = 0;
            mod_out   = 0;
        endfunction

        function void set_register(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_CARRIER_WAVE: car_shape = value[1:0];
                REG_MOD_WAVE:     mod_shape = value[1:0];
                REG_FEEDBACK:     fb_gain   = value[15:0];
                REG_MOD_MODE:     pm_mode   = value[0];
                REG_MOD_RATIO:    ratio     = value[15:0];
                REG_MOD_LEVEL:    level     = value[15:0];
                REG_LFO_DEPTH:    depth     = value[15:0];
                default: ;
            endcase
        endfunction

        function longint clamp(longint v);
            if (v > MAX_S) return MAX_S;
            if (v < -ONE_S) return -ONE_S;
            return v;
        endfunction

        // Product shifted right, rounded toward minus infinity.
        function longint floor_product(longint a, longint b, int sh);
            longint p;
            p = a * b;
            return p >>> sh;
        endfunction

        function longint shape_value(logic [1:0] shape, logic [31:0] p);
            logic [1:0]  q;
            longint      a;
            longint      r;
            int          idx;
            q   = p[31:30];
            a   = (longint'(p[29:0]) * ONE_S) >>> 30;
            r   = (longint'(p[30:0]) * ONE_S) >>> 31;
            idx = int'(p[29:30-SINE_TABLE_BITS]);
            case (shape)
                WAVE_SINE:
                begin
                    if (q == 0) return quarter_sine[idx];
                    if (q == 1) return quarter_sine[QUARTER_N - idx];
                    if (q == 2) return -quarter_sine[idx];
                    return -quarter_sine[QUARTER_N - idx];
                end
                WAVE_TRIANGLE:
                begin
                    if (q == 0) return a;
                    if (q == 1) return clamp(ONE_S - a);
                    if (q == 2) return -a;
                    return a - ONE_S;
                end
                WAVE_SQUARE:
                    return (q == 0 || q == 3) ? MAX_S : -ONE_S;
                default:
                    return p[31] ? r - ONE_S : r;
            endcase
        endfunction

        function logic [31:0] phase_offset(longint v);
            logic [63:0] w;
            if (pm_mode)
                w = floor_product(v, 683565276, SAMPLE_BITS - 1);
            else
                w = v << (33 - SAMPLE_BITS);
            return w[31:0];
        endfunction

        // Notes one accepted word and queues the sample it should produce.
        function void note_word(logic act, logic [31:0] step, logic signed [15:0] lfo);
            longint      fb;
            longint      g;
            longint      t;
            logic [63:0] c;
            logic [47:0] mstep;
            if (act)
            begin
                car_out = 0;
                mod_out = 0;
                return;
            end
            fb = floor_product(mod_out, fb_gain, 16);
            g  = (longint'(65536 - depth) <<< 15) + longint'(depth) * longint'(lfo);
            t  = floor_product(shape_value(mod_shape, mod_phase + phase_offset(fb)),
                               level, 16);
            mod_out = clamp(floor_product(t, g, 31));
            car_out = shape_value(car_shape, car_phase + phase_offset(mod_out));
            c = car_out << (32 - SAMPLE_BITS);
            pending_samples.push_back(c[31:0]);
            mstep     = (48'(step) * ratio) >> 8;
            car_phase = car_phase + step;
            mod_phase = mod_phase + mstep[31:0];
        endfunction

        // Prints one line for a mismatch and counts it.
        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_sample(logic signed [31:0] got);
            logic signed [31:0] want;
            if (pending_samples.size() == 0)
            begin
                report_mismatch($sformatf("sample %0d with nothing pending", got));
                return;
            end
            want = pending_samples.pop_front();
            if (got !== want)
                report_mismatch($sformatf("sample %0d, expected %0d", got, want));
            else
                matched++;
        endtask
    endclass

endpackage

FILE: tb/tb_top.sv
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import tofpo_pkg::*;
    import tofpo_tb_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tofpo_in_if  in_ch ();
    tofpo_out_if out_ch ();

    two_operator_fm_pm_oscillator_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source)
    );

    voice_scoreboard board;

    // Idle shares in percent for the sender and the receiver.
    int send_idle_pct;
    int recv_idle_pct;
    int idle_cycles = 0;
    int words_sent;
    bit finished;

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // The receiver stalls at random; each accepted word is checked at the edge
    // that accepts it, so nothing depends on event order within a step.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
                board.check_sample(out_ch.sample);
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // The watchdog counts cycles in which no word moves on either channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 20000 && !finished)
            begin
                $display("watchdog expired");
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    // One APB write: a setup phase, then an access phase that commits it.
    task automatic write_register(logic [2:0] idx, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_register(idx, value);
    endtask

    // Sends one word, idling first at random, and holds it until it is taken.
    task automatic send_word(logic act, logic [31:0] step, logic signed [15:0] lfo);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(posedge clk);
            in_ch.valid <= 1'b0;
        end
        @(posedge clk);
        in_ch.valid      <= 1'b1;
        in_ch.action     <= act;
        in_ch.phase_step <= step;
        in_ch.lfo        <= lfo;
        do
            @(posedge clk);
        while (!in_ch.ready);
        board.note_word(act, step, lfo);
        in_ch.valid <= 1'b0;
        words_sent++;
    endtask

    // Waits until every pending sample is out, plus the latency of a tick.
    task automatic drain();
        while (board.pending_samples.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Random word: mostly ticks with an occasional note off.
    task automatic send_random();
        logic [31:0] step;
        case ($urandom_range(3))
            0: step = $urandom_range(4000000);
            1: step = $urandom;
            2: step = 32'hFFFF_FFFF - $urandom_range(3);
            default: step = $urandom_range(200000000);
        endcase
        send_word($urandom_range(15) == 0, step, 16'($urandom));
    endtask

    // Random register setting; extremes come up often.
    task automatic randomize_registers();
        logic [15:0] v;
        for (int i = 0; i < 7; i++)
        begin
            case ($urandom_range(3))
                0: v = 16'h0000;
                1: v = 16'hFFFF;
                default: v = 16'($urandom);
            endcase
            if (i == REG_MOD_RATIO && $urandom_range(1))
                v = 16'($urandom_range(1024));
            write_register(3'(i), {16'($urandom), v});
        end
    endtask

    initial
    begin
        board = new();
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        in_ch.valid      = 1'b0;
        in_ch.action     = 1'b0;
        in_ch.phase_step = '0;
        in_ch.lfo        = '0;
        words_sent    = 0;
        finished      = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: every shape on both operators, both modulation modes,
        // extreme steps and LFO values, and note offs between ticks.
        for (int s = 0; s < 4; s++)
        begin
            write_register(REG_CARRIER_WAVE, s);
            write_register(REG_MOD_WAVE, 3 - s);
            write_register(REG_MOD_MODE, s & 1);
            write_register(REG_FEEDBACK, (s == 0) ? 0 : 16'hFFFF);
            send_word(1'b0, 32'h0000_0000, 16'sh7FFF);
            send_word(1'b0, 32'hFFFF_FFFF, -16'sh8000);
            send_word(1'b0, 32'h4000_0000, 16'sh0000);
            send_word(1'b1, 32'hFFFF_FFFF, -16'sh0001);
            send_word(1'b0, 32'h1234_5678, 16'sh4000);
            drain();
        end

        // Random part in three idling phases with register changes between.
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 88 : 0;
            recv_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 24 : 0;
            for (int blk = 0; blk < 9; blk++)
            begin
                drain();
                randomize_registers();
                for (int n = 0; n < 50; n++)
                    send_random();
            end
        end

        drain();
        finished = 1;
        $display("%0d words sent, %0d samples matched, all shapes and modes visited",
                 words_sent, board.matched);
        if (board.errors == 0 && board.pending_samples.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
